@@ rtl/wfcd_pkg.sv @@
package wfcd_pkg;

  localparam int ID_W       = 4;
  localparam int OP_W       = 2;
  localparam int PATH_DEPTH = 16;
  localparam int PIDX_W     = 4;
  localparam int LEN_W      = 5;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] waiter;
    logic [ID_W-1:0] target;
    logic            target_present;
  } in_item_t;

  typedef struct packed {
    logic            deadlock_found;
    logic            rejected;
    logic            entry_found;
    logic [ID_W-1:0] target_out;
    logic [ID_W-1:0] member_id;
    logic            last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_STEP,
    ST_QUERY,
    ST_RESP,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/wfcd_tgt_ram.sv @@
module wfcd_tgt_ram #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [wfcd_pkg::ID_W-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [wfcd_pkg::ID_W-1:0]    rdata
);

  logic [wfcd_pkg::ID_W-1:0] mem [DEPTH];
  logic [wfcd_pkg::ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/wait_for_cycle_detector_core.sv @@
// path to the result register: clear, rejected or unwalked append go to ST_RESP; a query passes
// ST_QUERY; a walk passes ST_LOOKUP, then ST_STEP once per chain link (at most NUM_AGENTS + 1),
// then ST_RESP, or ST_EMIT which loads one result per path member; each load waits on out_stall
// throughput: one item at a time, the next accepted the cycle after the last result loads
// reset: synchronous active low, clears the table valid bits, the deadlock latch, the visited set,
// the sequencer and the result valid flag; the target ram and the result data are not cleared
module wait_for_cycle_detector_core #(
  parameter int NUM_AGENTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wfcd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wfcd_pkg::out_item_t  out_data
);

  localparam int AW = $clog2(NUM_AGENTS);
  localparam int SW = $clog2(NUM_AGENTS + 1);

  wfcd_pkg::state_t state_r, state_nxt;

  logic [wfcd_pkg::ID_W-1:0]  cur_r, cur_nxt;
  logic [SW-1:0]              steps_r, steps_nxt;
  logic [wfcd_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [wfcd_pkg::LEN_W-1:0] emit_idx_r, emit_idx_nxt;
  logic [NUM_AGENTS-1:0]      visited_r, visited_nxt;
  logic [NUM_AGENTS-1:0]      valid_r, valid_nxt;
  logic [NUM_AGENTS-1:0]      has_r, has_nxt;
  logic                       latched_r, latched_nxt;
  wfcd_pkg::out_item_t        resp_r, resp_nxt;
  wfcd_pkg::out_item_t        out_data_r, out_load_data;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_load;
  logic                       out_free;

  logic [wfcd_pkg::ID_W-1:0]  path_r [wfcd_pkg::PATH_DEPTH];
  logic                       path_we;
  logic [wfcd_pkg::PIDX_W-1:0] path_waddr;
  logic [wfcd_pkg::ID_W-1:0]  path_wdata;

  logic                       mem_we;
  logic [wfcd_pkg::ID_W-1:0]  mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [wfcd_pkg::ID_W-1:0]  rd_data;

  logic                       accept;
  logic                       w_in_range, cur_in_range, nxt_in_range;
  logic [AW-1:0]              w_idx, cur_idx, nxt_idx;
  logic [NUM_AGENTS-1:0]      w_bit, cur_bit, visited_cur;
  logic                       cur_ok, cur_has, vis_nxt, closes, can_push;
  wfcd_pkg::out_item_t        single;

  wfcd_tgt_ram #(
    .DEPTH (NUM_AGENTS)
  ) u_tgt_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (w_idx),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign accept       = in_valid && !in_stall;
  assign in_stall     = (state_r != wfcd_pkg::ST_IDLE);
  assign out_free     = !out_valid_r || !out_stall;

  assign w_in_range   = 32'(in_data.waiter) < NUM_AGENTS;
  assign cur_in_range = 32'(cur_r) < NUM_AGENTS;
  assign nxt_in_range = 32'(rd_data) < NUM_AGENTS;
  assign w_idx        = AW'(in_data.waiter);
  assign cur_idx      = AW'(cur_r);
  assign nxt_idx      = AW'(rd_data);
  assign w_bit        = w_in_range ? (NUM_AGENTS'(1) << in_data.waiter) : '0;
  assign cur_bit      = cur_in_range ? (NUM_AGENTS'(1) << cur_r) : '0;
  assign visited_cur  = visited_r | cur_bit;
  assign cur_ok       = cur_in_range && valid_r[cur_idx];
  assign cur_has      = has_r[cur_idx];
  assign vis_nxt      = nxt_in_range && visited_cur[nxt_idx];
  assign closes       = vis_nxt && ((rd_data != cur_r) || (rd_data == path_r[0]));
  assign can_push     = len_r < wfcd_pkg::LEN_W'(wfcd_pkg::PATH_DEPTH);

  always_comb begin
    single      = '0;
    single.last = 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    len_nxt       = len_r;
    emit_idx_nxt  = emit_idx_r;
    visited_nxt   = visited_r;
    valid_nxt     = valid_r;
    has_nxt       = has_r;
    latched_nxt   = latched_r;
    resp_nxt      = resp_r;
    path_we       = 1'b0;
    path_waddr    = '0;
    path_wdata    = in_data.waiter;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    mem_raddr     = cur_idx;
    out_load      = 1'b0;
    out_load_data = resp_r;

    unique case (state_r)
      wfcd_pkg::ST_IDLE: begin
        mem_raddr = w_idx;
        if (accept) begin
          resp_nxt  = single;
          state_nxt = wfcd_pkg::ST_RESP;
          cur_nxt   = in_data.waiter;
          unique case (in_data.operation)
            wfcd_pkg::OP_APPEND: begin
              if (latched_r) begin
                resp_nxt.rejected = 1'b1;
              end else if (w_in_range) begin
                mem_we           = 1'b1;
                mem_wdata        = in_data.target_present ? in_data.target : '0;
                valid_nxt[w_idx] = 1'b1;
                has_nxt[w_idx]   = in_data.target_present;
                path_we          = 1'b1;
                len_nxt          = wfcd_pkg::LEN_W'(1);
                visited_nxt      = w_bit;
                if (in_data.target_present) begin
                  cur_nxt   = in_data.target;
                  steps_nxt = '0;
                  state_nxt = wfcd_pkg::ST_LOOKUP;
                end
              end
            end
            wfcd_pkg::OP_CLEAR: begin
              if (w_in_range) begin
                mem_we           = 1'b1;
                valid_nxt[w_idx] = 1'b0;
                has_nxt[w_idx]   = 1'b0;
              end
            end
            wfcd_pkg::OP_QUERY: begin
              state_nxt = wfcd_pkg::ST_QUERY;
            end
            default: begin
              state_nxt = wfcd_pkg::ST_RESP;
            end
          endcase
        end
      end
      wfcd_pkg::ST_LOOKUP: begin
        state_nxt = wfcd_pkg::ST_STEP;
      end
      wfcd_pkg::ST_STEP: begin
        mem_raddr = nxt_idx;
        if (!cur_ok) begin
          state_nxt = wfcd_pkg::ST_RESP;
        end else if (!cur_has) begin
          visited_nxt = visited_cur;
          state_nxt   = wfcd_pkg::ST_RESP;
        end else begin
          visited_nxt = visited_cur;
          if (can_push) begin
            path_we    = 1'b1;
            path_waddr = len_r[wfcd_pkg::PIDX_W-1:0];
            path_wdata = cur_r;
            len_nxt    = len_r + wfcd_pkg::LEN_W'(1);
          end
          if (closes) begin
            latched_nxt  = 1'b1;
            emit_idx_nxt = '0;
            state_nxt    = wfcd_pkg::ST_EMIT;
          end else if (steps_r == SW'(NUM_AGENTS)) begin
            state_nxt = wfcd_pkg::ST_RESP;
          end else begin
            cur_nxt   = rd_data;
            steps_nxt = steps_r + SW'(1);
          end
        end
      end
      wfcd_pkg::ST_QUERY: begin
        if (cur_ok && cur_has) begin
          resp_nxt.entry_found = 1'b1;
          resp_nxt.target_out  = rd_data;
        end
        state_nxt = wfcd_pkg::ST_RESP;
      end
      wfcd_pkg::ST_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = wfcd_pkg::ST_IDLE;
        end
      end
      wfcd_pkg::ST_EMIT: begin
        out_load_data                = '0;
        out_load_data.deadlock_found = 1'b1;
        out_load_data.member_id      = path_r[emit_idx_r[wfcd_pkg::PIDX_W-1:0]];
        out_load_data.last           = (emit_idx_r + wfcd_pkg::LEN_W'(1)) == len_r;
        if (out_free) begin
          out_load     = 1'b1;
          emit_idx_nxt = emit_idx_r + wfcd_pkg::LEN_W'(1);
          if (out_load_data.last) begin
            state_nxt = wfcd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = wfcd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wfcd_pkg::ST_IDLE;
      latched_r   <= 1'b0;
      valid_r     <= '0;
      has_r       <= '0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      latched_r   <= latched_nxt;
      valid_r     <= valid_nxt;
      has_r       <= has_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    steps_r    <= steps_nxt;
    len_r      <= len_nxt;
    emit_idx_r <= emit_idx_nxt;
    resp_r     <= resp_nxt;
    if (out_load) begin
      out_data_r <= out_load_data;
    end
    if (path_we) begin
      path_r[path_waddr] <= path_wdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    latched_r |=> latched_r)
    else $error("deadlock latch dropped without reset");

  a_reject_needs_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.rejected) |-> latched_r)
    else $error("rejected result while no deadlock latched");

  a_report_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.deadlock_found && (out_data.rejected || out_data.entry_found)))
    else $error("deadlock report mixed with another result kind");

  a_emit_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wfcd_pkg::ST_EMIT) |-> (emit_idx_r < len_r))
    else $error("path report index beyond recorded path");

endmodule
